// ===== sv/rca_pkg.sv =====
// Route cost accumulator: shared types, constants and helper functions.
// Used by every module of the block; no dependencies of its own.
package rca_pkg;

  // Field and datapath widths
  localparam int LAT_W   = 30;
  localparam int LON_W   = 31;
  localparam int SCORE_W = 16;
  localparam int CFG_W   = 16;
  localparam int LEG_W   = 9;
  localparam int COST_W  = 48;
  localparam int ANG_W   = 34;  // CORDIC x, y, z (Q30 plus headroom)
  localparam int MUL_W   = 33;  // shared multiplier operand
  localparam int PROD_W  = 66;  // shared multiplier product
  localparam int DEG_W   = 30;  // reduced angle in degrees Q22
  localparam int DIF_W   = 33;  // coordinate difference
  localparam int SQ_W    = 61;  // square root radicand
  localparam int ROOT_W  = 31;
  localparam int ITER_IW = 6;   // CORDIC iteration index

  localparam int MAX_LEGS_DEF    = 256;
  localparam int CORDIC_ITER_DEF = 24;

  // Fixed-point constants
  localparam logic signed [ANG_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] ARC_MAX  = 34'sd1686629713;
  localparam logic signed [DIF_W-1:0] DEG90    = 33'sd377487360;
  localparam logic signed [DIF_W-1:0] DEG180   = 33'sd754974720;
  localparam logic signed [DIF_W-1:0] DEG360   = 33'sd1509949440;
  // pi/180 * 2^40 split as K_HI * 2^18 + K_LO
  localparam logic [17:0] K_LO = 18'd108693;
  localparam logic [17:0] K_HI = 18'd73204;
  localparam int K_SPLIT = 18;

  // Configuration register indexes
  localparam logic [1:0] REG_URGENCY_WEIGHT = 2'd0;
  localparam logic [1:0] REG_ANOMALY_WEIGHT = 2'd1;
  localparam logic [1:0] REG_EARTH_RADIUS   = 2'd2;
  localparam logic [1:0] REG_LEG_TOTAL      = 2'd3;

  localparam logic [CFG_W-1:0] URG_W_RST  = 16'd640;
  localparam logic [CFG_W-1:0] ANO_W_RST  = 16'd384;
  localparam logic [CFG_W-1:0] RADIUS_RST = 16'd6371;
  localparam logic [LEG_W-1:0] LEGS_RST   = 9'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ANG, ST_RAD_LO, ST_RAD_HI, ST_RAD_ACC, ST_ROT,
    ST_MUL, ST_MUL_WB, ST_SQY_GO, ST_SQY, ST_SQX_GO, ST_SQX,
    ST_ARC_GO, ST_ARC, ST_ACC, ST_ACC2, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_S1SQ, OP_S2SQ, OP_C12, OP_T2C, OP_DIST,
    OP_PU0, OP_PU1, OP_PA0, OP_PA1
  } op_e;

  typedef enum logic {
    CM_ROTATE, CM_VECTOR
  } cmode_e;

  typedef struct packed {
    logic   start;
    cmode_e mode;
  } cor_ctrl_t;

  // Arctangent step for CORDIC iteration i, radians Q30
  function automatic logic signed [ANG_W-1:0] arc_step(input logic [ITER_IW-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      6'd0: r = 34'sd843314857;
      6'd1: r = 34'sd497837829;
      6'd2: r = 34'sd263043837;
      6'd3: r = 34'sd133525159;
      6'd4: r = 34'sd67021687;
      6'd5: r = 34'sd33543516;
      6'd6: r = 34'sd16775851;
      6'd7: r = 34'sd8388437;
      6'd8: r = 34'sd4194283;
      6'd9: r = 34'sd2097149;
      default: begin
        if (i <= 6'd30) r = ANG_W'(1) << (6'd30 - i);
        else r = '0;
      end
    endcase
    return r;
  endfunction

  // Saturating 48 bit add; top bit of the result flags saturation
  function automatic logic [COST_W:0] sat_add(input logic [COST_W-1:0] acc,
                                              input logic [COST_W-1:0] v);
    logic [COST_W:0] s;
    s = {1'b0, acc} + {1'b0, v};
    if (s[COST_W]) s = {1'b1, {COST_W{1'b1}}};
    return s;
  endfunction

endpackage

// ===== sv/route_cost_accumulator.sv =====
// Route cost accumulator: top level with the sequencer and route state.
// Depends on rca_pkg, rca_mul, rca_isqrt and rca_cordic.
//
// Usage: stops of a route enter one per transaction on the s_axis channel in
// route order; tlast marks the final stop. The total cost of the route leaves
// on the m_axis channel as one transaction after that final stop.
// The cfg port writes the weights, sphere radius and leg count; the user must
// write them only while idle, as the block itself does not enforce it. Every
// stop after the first of a route runs four CORDIC rotations, two square roots
// of 31 digits and one CORDIC vectoring on shared units, plus up to seventeen
// passes through the shared multiplier.
// s_axis_tready is high only between stops. A finished total waits in an
// output register; the next stops are still taken, and only the next final
// stop waits for m_axis_tready if the previous total has not been taken.
// Reset restores the register defaults and clears the route state.
module route_cost_accumulator #(
  parameter int MAX_LEGS          = rca_pkg::MAX_LEGS_DEF,
  parameter int CORDIC_ITERATIONS = rca_pkg::CORDIC_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [29:0] latitude, [60:30] longitude, [76:61] urgency, [92:77] anomaly
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] is_hub
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [47:0] total_cost
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] overflow
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int PW = $clog2(MAX_LEGS + 1);
  localparam int RW = (PW > rca_pkg::LEG_W) ? PW : rca_pkg::LEG_W;
  localparam int CW = rca_pkg::COST_W;
  localparam int AW = rca_pkg::ANG_W;
  localparam int MW = rca_pkg::MUL_W;
  localparam int QW = rca_pkg::PROD_W;

  // Configuration
  logic [rca_pkg::CFG_W-1:0] uw_q, aw_q, rad_q;
  logic [rca_pkg::LEG_W-1:0] legs_q;

  // Current stop and route state
  logic signed [rca_pkg::LAT_W-1:0] lat_q, prev_lat_q;
  logic signed [rca_pkg::LON_W-1:0] lon_q, prev_lon_q;
  logic [rca_pkg::SCORE_W-1:0] urg_q, ano_q;
  logic hub_q, last_q, sat_q;
  logic [PW-1:0] pos_q;
  logic [CW-1:0] dsum_q, psum_q;

  // Sequencer
  rca_pkg::state_e state_q, state_d;
  rca_pkg::op_e    op_q, op_d;
  logic [1:0]      k_q;

  // Working registers
  logic [rca_pkg::DEG_W-1:0] deg_q, deg_d;
  logic half_q, neg_q, neg_d;
  logic [QW-1:0] lo_q;
  logic signed [MW-1:0] s1_q, s2_q, c1_q, c2_q, term1_q, t2_q, c12_q, cc_q, tmp_q;
  logic [rca_pkg::ROOT_W-1:0] a_q, ya_q, xa_q;
  logic [CW-1:0] dist_q, pu_q, pa_q;

  // Output register
  logic out_valid_q, out_ovf_q;
  logic [CW-1:0] out_cost_q;

  // Shared units
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [QW-1:0] prod;
  rca_pkg::cor_ctrl_t cor_ctrl;
  logic signed [AW-1:0] cor_x, cor_y, cor_z, cor_a, cor_b;
  logic cor_busy, cor_done;
  logic sq_start, sq_done;
  logic [rca_pkg::SQ_W-1:0] sq_v;
  logic [rca_pkg::ROOT_W-1:0] sq_root;

  // Combinational helpers
  logic s_acc, m_acc, out_stall, first_stop;
  logic signed [rca_pkg::DIF_W-1:0] dif, r0, r1, r2, lsel, mabs;
  logic [QW-1:0] rad_full;
  logic signed [AW-1:0] theta;
  logic signed [AW-1:0] a_sum;
  logic [RW-1:0] rest;
  logic [CW:0] sum_d, sum_p, sum_p2, sum_t;

  rca_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rca_cordic #(
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cor_ctrl),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .z_i     (cor_z),
    .busy_o  (cor_busy),
    .done_o  (cor_done),
    .res_a_o (cor_a),
    .res_b_o (cor_b)
  );

  rca_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     (sq_v),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign m_acc      = m_axis_tvalid && m_axis_tready;
  assign out_stall  = last_q && out_valid_q && !m_axis_tready;
  assign first_stop = (pos_q == '0);

  // Angle reduction: half-difference for sines, folded latitude for cosines
  always_comb begin
    dif  = (k_q == 2'd0) ? (rca_pkg::DIF_W'(lat_q) - rca_pkg::DIF_W'(prev_lat_q))
                         : (rca_pkg::DIF_W'(lon_q) - rca_pkg::DIF_W'(prev_lon_q));
    // differences below minus a full turn need two turns added
    if (dif < -rca_pkg::DEG360) r0 = dif + rca_pkg::DEG360 + rca_pkg::DEG360;
    else if (dif < 0)           r0 = dif + rca_pkg::DEG360;
    else                        r0 = dif;
    r1   = (r0 >= rca_pkg::DEG360) ? r0 - rca_pkg::DEG360 : r0;
    r2   = (r1 > rca_pkg::DEG180) ? rca_pkg::DEG360 - r1 : r1;
    lsel = (k_q == 2'd2) ? rca_pkg::DIF_W'(prev_lat_q) : rca_pkg::DIF_W'(lat_q);
    mabs = (lsel < 0) ? -lsel : lsel;
    neg_d = 1'b0;
    if (k_q[1]) begin
      if (mabs > rca_pkg::DEG90) begin
        deg_d = rca_pkg::DEG_W'(rca_pkg::DEG180 - mabs);
        neg_d = 1'b1;
      end else begin
        deg_d = rca_pkg::DEG_W'(mabs);
      end
    end else begin
      deg_d = rca_pkg::DEG_W'(r2);
    end
  end

  // Degrees to radians: combine the two partial products and round
  always_comb begin
    rad_full = lo_q + (QW'(prod) << rca_pkg::K_SPLIT);
    if (half_q) theta = AW'((rad_full + (QW'(1) << 32)) >> 33);
    else        theta = AW'((rad_full + (QW'(1) << 31)) >> 32);
  end

  // Haversine term and penalty factor
  assign a_sum = AW'(term1_q) + AW'(prod >>> 30);
  assign rest  = (RW'(legs_q) > RW'(pos_q)) ? RW'(legs_q) - RW'(pos_q) : '0;

  // Sums
  assign sum_d  = rca_pkg::sat_add(dsum_q, dist_q);
  assign sum_p  = rca_pkg::sat_add(psum_q, hub_q ? '0 : pu_q);
  assign sum_p2 = rca_pkg::sat_add(psum_q, hub_q ? '0 : pa_q);
  assign sum_t  = rca_pkg::sat_add(dsum_q, psum_q);

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      rca_pkg::ST_IDLE:    if (s_acc) state_d = first_stop ? rca_pkg::ST_DONE
                                                           : rca_pkg::ST_ANG;
      rca_pkg::ST_ANG:     state_d = rca_pkg::ST_RAD_LO;
      rca_pkg::ST_RAD_LO:  state_d = rca_pkg::ST_RAD_HI;
      rca_pkg::ST_RAD_HI:  state_d = rca_pkg::ST_RAD_ACC;
      rca_pkg::ST_RAD_ACC: state_d = rca_pkg::ST_ROT;
      rca_pkg::ST_ROT: begin
        if (cor_done) begin
          if (k_q == 2'd3) begin
            state_d = rca_pkg::ST_MUL;
            op_d    = rca_pkg::OP_S1SQ;
          end else begin
            state_d = rca_pkg::ST_ANG;
          end
        end
      end
      rca_pkg::ST_MUL:     state_d = rca_pkg::ST_MUL_WB;
      rca_pkg::ST_MUL_WB: begin
        state_d = rca_pkg::ST_MUL;
        unique case (op_q)
          rca_pkg::OP_S1SQ: op_d = rca_pkg::OP_S2SQ;
          rca_pkg::OP_S2SQ: op_d = rca_pkg::OP_C12;
          rca_pkg::OP_C12:  op_d = rca_pkg::OP_T2C;
          rca_pkg::OP_T2C:  state_d = rca_pkg::ST_SQY_GO;
          rca_pkg::OP_DIST: begin
            if (hub_q) state_d = rca_pkg::ST_ACC;
            else       op_d    = rca_pkg::OP_PU0;
          end
          rca_pkg::OP_PU0:  op_d = rca_pkg::OP_PU1;
          rca_pkg::OP_PU1:  op_d = rca_pkg::OP_PA0;
          rca_pkg::OP_PA0:  op_d = rca_pkg::OP_PA1;
          rca_pkg::OP_PA1:  state_d = rca_pkg::ST_ACC;
          default:          state_d = rca_pkg::ST_ACC;
        endcase
      end
      rca_pkg::ST_SQY_GO:  state_d = rca_pkg::ST_SQY;
      rca_pkg::ST_SQY:     if (sq_done) state_d = rca_pkg::ST_SQX_GO;
      rca_pkg::ST_SQX_GO:  state_d = rca_pkg::ST_SQX;
      rca_pkg::ST_SQX:     if (sq_done) state_d = rca_pkg::ST_ARC_GO;
      rca_pkg::ST_ARC_GO:  state_d = rca_pkg::ST_ARC;
      rca_pkg::ST_ARC: begin
        if (cor_done) begin
          state_d = rca_pkg::ST_MUL;
          op_d    = rca_pkg::OP_DIST;
        end
      end
      rca_pkg::ST_ACC:     state_d = rca_pkg::ST_ACC2;
      rca_pkg::ST_ACC2:    state_d = rca_pkg::ST_DONE;
      rca_pkg::ST_DONE:    if (!out_stall) state_d = rca_pkg::ST_IDLE;
      default:             state_d = rca_pkg::ST_IDLE;
    endcase
  end

  // Unit controls and operand selection
  always_comb begin
    s_axis_tready = (state_q == rca_pkg::ST_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    cor_ctrl      = '{start: 1'b0, mode: rca_pkg::CM_ROTATE};
    cor_x         = rca_pkg::GAIN_Q30;
    cor_y         = '0;
    cor_z         = theta;
    sq_start      = 1'b0;
    sq_v          = rca_pkg::SQ_W'(a_q) << 30;
    unique case (state_q)
      rca_pkg::ST_RAD_LO: begin
        mul_a = MW'(deg_q);
        mul_b = MW'(rca_pkg::K_LO);
      end
      rca_pkg::ST_RAD_HI: begin
        mul_a = MW'(deg_q);
        mul_b = MW'(rca_pkg::K_HI);
      end
      rca_pkg::ST_RAD_ACC: cor_ctrl.start = 1'b1;
      rca_pkg::ST_MUL: begin
        unique case (op_q)
          rca_pkg::OP_S1SQ: begin mul_a = s1_q;    mul_b = s1_q;  end
          rca_pkg::OP_S2SQ: begin mul_a = s2_q;    mul_b = s2_q;  end
          rca_pkg::OP_C12:  begin mul_a = c1_q;    mul_b = c2_q;  end
          rca_pkg::OP_T2C:  begin mul_a = t2_q;    mul_b = c12_q; end
          rca_pkg::OP_DIST: begin mul_a = MW'(rad_q); mul_b = cc_q; end
          rca_pkg::OP_PU0:  begin mul_a = MW'(pos_q); mul_b = MW'(urg_q); end
          rca_pkg::OP_PU1:  begin mul_a = tmp_q;   mul_b = MW'(uw_q); end
          rca_pkg::OP_PA0:  begin mul_a = MW'(rest);  mul_b = MW'(ano_q); end
          rca_pkg::OP_PA1:  begin mul_a = tmp_q;   mul_b = MW'(aw_q); end
          default:          begin mul_a = '0;      mul_b = '0;    end
        endcase
      end
      rca_pkg::ST_SQY_GO: sq_start = 1'b1;
      rca_pkg::ST_SQX_GO: begin
        sq_start = 1'b1;
        sq_v     = rca_pkg::SQ_W'(rca_pkg::ROOT_W'(rca_pkg::ONE_Q30) - a_q) << 30;
      end
      rca_pkg::ST_ARC_GO: begin
        cor_ctrl = '{start: 1'b1, mode: rca_pkg::CM_VECTOR};
        cor_x    = AW'(xa_q);
        cor_y    = AW'(ya_q);
        cor_z    = '0;
      end
      default: ;
    endcase
  end

  // Control, configuration and route state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rca_pkg::ST_IDLE;
      op_q        <= rca_pkg::OP_S1SQ;
      k_q         <= '0;
      uw_q        <= rca_pkg::URG_W_RST;
      aw_q        <= rca_pkg::ANO_W_RST;
      rad_q       <= rca_pkg::RADIUS_RST;
      legs_q      <= rca_pkg::LEGS_RST;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      pos_q       <= '0;
      dsum_q      <= '0;
      psum_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rca_pkg::REG_URGENCY_WEIGHT: uw_q   <= cfg_data_i;
          rca_pkg::REG_ANOMALY_WEIGHT: aw_q   <= cfg_data_i;
          rca_pkg::REG_EARTH_RADIUS:   rad_q  <= cfg_data_i;
          rca_pkg::REG_LEG_TOTAL:      legs_q <= cfg_data_i[rca_pkg::LEG_W-1:0];
          default: ;
        endcase
      end
      if (s_acc) k_q <= '0;
      else if (state_q == rca_pkg::ST_ROT && cor_done) k_q <= k_q + 2'd1;
      // A new total replaces one taken in the same cycle
      if (state_q == rca_pkg::ST_DONE && !out_stall && last_q) out_valid_q <= 1'b1;
      else if (m_acc)                                          out_valid_q <= 1'b0;
      unique case (state_q)
        rca_pkg::ST_ACC: begin
          dsum_q <= sum_d[CW-1:0];
          psum_q <= sum_p[CW-1:0];
          if (sum_d[CW] || sum_p[CW]) sat_q <= 1'b1;
        end
        rca_pkg::ST_ACC2: begin
          psum_q <= sum_p2[CW-1:0];
          if (sum_p2[CW]) sat_q <= 1'b1;
        end
        rca_pkg::ST_DONE: begin
          if (!out_stall) begin
            if (last_q) begin
              prev_lat_q  <= '0;
              prev_lon_q  <= '0;
              pos_q       <= '0;
              dsum_q      <= '0;
              psum_q      <= '0;
              sat_q       <= 1'b0;
            end else begin
              prev_lat_q <= lat_q;
              prev_lon_q <= lon_q;
              if (pos_q < PW'(MAX_LEGS)) pos_q <= pos_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      lat_q  <= s_axis_tdata[29:0];
      lon_q  <= s_axis_tdata[60:30];
      urg_q  <= s_axis_tdata[76:61];
      ano_q  <= s_axis_tdata[92:77];
      hub_q  <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (state_q == rca_pkg::ST_ANG) begin
      deg_q  <= deg_d;
      half_q <= !k_q[1];
      neg_q  <= neg_d;
    end
    if (state_q == rca_pkg::ST_RAD_HI) lo_q <= QW'(prod);
    if (state_q == rca_pkg::ST_ROT && cor_done) begin
      unique case (k_q)
        2'd0: s1_q <= MW'(cor_b);
        2'd1: s2_q <= MW'(cor_b);
        2'd2: c1_q <= neg_q ? -MW'(cor_a) : MW'(cor_a);
        2'd3: c2_q <= neg_q ? -MW'(cor_a) : MW'(cor_a);
        default: ;
      endcase
    end
    if (state_q == rca_pkg::ST_MUL_WB) begin
      unique case (op_q)
        rca_pkg::OP_S1SQ: term1_q <= MW'(prod >>> 30);
        rca_pkg::OP_S2SQ: t2_q    <= MW'(prod >>> 30);
        rca_pkg::OP_C12:  c12_q   <= MW'(prod >>> 30);
        rca_pkg::OP_T2C: begin
          if (a_sum < 0)                     a_q <= '0;
          else if (a_sum > rca_pkg::ONE_Q30) a_q <= rca_pkg::ROOT_W'(rca_pkg::ONE_Q30);
          else                               a_q <= rca_pkg::ROOT_W'(a_sum);
        end
        rca_pkg::OP_DIST: begin
          dist_q <= CW'((prod + (QW'(1) << 21)) >>> 22);
          pu_q   <= '0;
          pa_q   <= '0;
        end
        rca_pkg::OP_PU0:  tmp_q <= MW'(prod);
        rca_pkg::OP_PU1:  pu_q  <= CW'((prod + QW'(128)) >>> 8);
        rca_pkg::OP_PA0:  tmp_q <= MW'(prod);
        rca_pkg::OP_PA1:  pa_q  <= CW'((prod + QW'(128)) >>> 8);
        default: ;
      endcase
    end
    if (state_q == rca_pkg::ST_SQY && sq_done) ya_q <= sq_root;
    if (state_q == rca_pkg::ST_SQX && sq_done) xa_q <= sq_root;
    if (state_q == rca_pkg::ST_ARC && cor_done) cc_q <= MW'(cor_a) <<< 1;
    if (state_q == rca_pkg::ST_DONE && !out_stall && last_q) begin
      out_cost_q <= sum_t[CW-1:0];
      out_ovf_q  <= sat_q || sum_t[CW];
    end
  end

  assign m_axis_tdata  = out_cost_q;
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tvalid = out_valid_q;

  // Shared CORDIC is only started when it is free
  a_cor_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_ctrl.start |-> !cor_busy)
    else $error("CORDIC started while busy");

  // A new total only appears out of the final step of a route
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == rca_pkg::ST_DONE)
    else $error("result raised outside the final step");

  // Route state is cleared after a total is produced
  a_route_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rca_pkg::ST_DONE && !out_stall && last_q)
      |=> (dsum_q == '0 && psum_q == '0 && pos_q == '0 && !sat_q))
    else $error("route state not cleared");

  // Position counter stays within its bound
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(MAX_LEGS))
    else $error("stop position beyond limit");

endmodule

// ===== sv/rca_mul.sv =====
// Route cost accumulator: shared signed multiplier with registered product.
// Depends on rca_pkg for widths.
module rca_mul (
  input  logic                              clk_i,
  input  logic signed [rca_pkg::MUL_W-1:0]  a_i,
  input  logic signed [rca_pkg::MUL_W-1:0]  b_i,
  output logic signed [rca_pkg::PROD_W-1:0] p_o
);

  logic signed [rca_pkg::PROD_W-1:0] p_q;

  // One product per cycle, registered and ready in the cycle after its operands
  always_ff @(posedge clk_i) begin
    p_q <= rca_pkg::PROD_W'(a_i) * rca_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== sv/rca_isqrt.sv =====
// Route cost accumulator: bit-serial integer square root, one digit per cycle.
// Depends on rca_pkg for widths.
module rca_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rca_pkg::SQ_W-1:0]     v_i,
  output logic                         done_o,
  output logic [rca_pkg::ROOT_W-1:0]   root_o
);

  logic [rca_pkg::SQ_W-1:0] v_q, r_q, bit_q, rb;
  logic busy_q, done_q;

  assign rb = r_q + bit_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Restoring digit step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      r_q   <= '0;
      bit_q <= rca_pkg::SQ_W'(1) << (rca_pkg::SQ_W - 1);
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[rca_pkg::ROOT_W-1:0];

endmodule

// ===== sv/rca_cordic.sv =====
// Route cost accumulator: shared CORDIC unit, rotation and vectoring modes.
// One iteration per cycle; depends on rca_pkg for the arc table and types.
module rca_cordic #(
  parameter int ITER = rca_pkg::CORDIC_ITER_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rca_pkg::cor_ctrl_t               ctrl_i,
  input  logic signed [rca_pkg::ANG_W-1:0] x_i,
  input  logic signed [rca_pkg::ANG_W-1:0] y_i,
  input  logic signed [rca_pkg::ANG_W-1:0] z_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [rca_pkg::ANG_W-1:0] res_a_o,  // cosine or arc
  output logic signed [rca_pkg::ANG_W-1:0] res_b_o   // sine
);

  localparam int IW = $clog2(ITER + 1);

  logic signed [rca_pkg::ANG_W-1:0] x_q, y_q, z_q, sx, sy, st;
  logic [IW-1:0] cnt_q;
  logic busy_q, done_q, dir;
  rca_pkg::cmode_e mode_q;

  // Shifted terms and direction for the current iteration
  always_comb begin
    sx  = x_q >>> cnt_q;
    sy  = y_q >>> cnt_q;
    st  = rca_pkg::arc_step(rca_pkg::ITER_IW'(cnt_q));
    dir = (mode_q == rca_pkg::CM_ROTATE) ? (z_q >= 0) : (y_q <= 0);
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == IW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Micro-rotation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      mode_q <= ctrl_i.mode;
    end else if (busy_q) begin
      if (dir) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - st;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + st;
      end
    end
  end

  // Clamped results
  always_comb begin
    if (mode_q == rca_pkg::CM_ROTATE) begin
      res_a_o = (x_q < 0) ? '0 : ((x_q > rca_pkg::ONE_Q30) ? rca_pkg::ONE_Q30 : x_q);
    end else begin
      res_a_o = (z_q < 0) ? '0 : ((z_q > rca_pkg::ARC_MAX) ? rca_pkg::ARC_MAX : z_q);
    end
    res_b_o = (y_q < 0) ? '0 : ((y_q > rca_pkg::ONE_Q30) ? rca_pkg::ONE_Q30 : y_q);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for route_cost_accumulator: random and directed routes checked
// against an in-bench fixed-point route cost predictor. Depends on rca_pkg.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic signed [rca_pkg::LAT_W-1:0] lat;
    logic signed [rca_pkg::LON_W-1:0] lon;
    logic [rca_pkg::SCORE_W-1:0]      urg;
    logic [rca_pkg::SCORE_W-1:0]      ano;
    logic                             hub;
    logic                             last;
  } stop_t;

  typedef struct {
    logic [rca_pkg::COST_W-1:0] cost;
    logic                       ovf;
  } route_total_t;

  // Predicts route totals and checks the outgoing transactions against them
  class route_scoreboard;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint ARC_LIMIT = 64'sd1686629713;
    localparam longint D90 = 64'sd377487360;
    localparam longint D180 = 64'sd754974720;
    localparam longint D360 = 64'sd1509949440;
    localparam longint unsigned RAD_PER_DEG = 64'd19190098069;
    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;

    longint unsigned w_urg, w_ano, radius, legs;
    longint prev_lat, prev_lon;
    longint unsigned pos, dist_acc, pen_acc;
    bit sat;
    route_total_t totals_q[$];
    int errors;

    function new();
      w_urg = rca_pkg::URG_W_RST; w_ano = rca_pkg::ANO_W_RST;
      radius = rca_pkg::RADIUS_RST; legs = rca_pkg::LEGS_RST;
      errors = 0;
      clear();
    endfunction

    function void clear();
      prev_lat = 0; prev_lon = 0; pos = 0; dist_acc = 0; pen_acc = 0; sat = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        rca_pkg::REG_URGENCY_WEIGHT: w_urg = val;
        rca_pkg::REG_ANOMALY_WEIGHT: w_ano = val;
        rca_pkg::REG_EARTH_RADIUS:   radius = val;
        rca_pkg::REG_LEG_TOTAL:      legs = val[rca_pkg::LEG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint atan_step(int i);
      longint tbl[10];
      tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
              33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tbl[i];
      if (i <= 30) return 64'sd1 << (30 - i);
      return 0;
    endfunction

    function longint clampv(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint deg_to_rad(longint unsigned deg, int extra);
      int sh;
      sh = 32 + extra;
      return longint'((deg * RAD_PER_DEG + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function void rotate(longint theta, output longint cs, output longint sn);
      longint x, y, z, nx;
      x = CORDIC_GAIN; y = 0; z = theta;
      for (int i = 0; i < rca_pkg::CORDIC_ITER_DEF; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
        end
        x = nx;
      end
      cs = clampv(x, 0, Q30);
      sn = clampv(y, 0, Q30);
    endfunction

    function longint arc(longint y, longint x);
      longint z, nx;
      z = 0;
      for (int i = 0; i < rca_pkg::CORDIC_ITER_DEF; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
        end else begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
        end
        x = nx;
      end
      return clampv(z, 0, ARC_LIMIT);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint half_sine(longint d);
      longint r, c, s;
      r = ((d % D360) + D360) % D360;
      if (r > D180) r = D360 - r;
      rotate(deg_to_rad(r, 1), c, s);
      return s;
    endfunction

    function longint lat_cos(longint lat);
      longint m, c, s;
      m = lat < 0 ? -lat : lat;
      if (m > D90) begin
        rotate(deg_to_rad(D180 - m, 0), c, s);
        return -c;
      end
      rotate(deg_to_rad(m, 0), c, s);
      return c;
    endfunction

    function longint unsigned leg_km(longint la1, longint lo1, longint la2, longint lo2);
      longint s1, s2, c12, t2, a;
      longint unsigned ya, xa, c;
      s1 = half_sine(la2 - la1);
      s2 = half_sine(lo2 - lo1);
      c12 = (lat_cos(la1) * lat_cos(la2)) >>> 30;
      t2 = (s2 * s2) >>> 30;
      a = ((s1 * s1) >>> 30) + ((t2 * c12) >>> 30);
      a = clampv(a, 0, Q30);
      ya = int_sqrt(longint'(a) << 30);
      xa = int_sqrt(longint'(Q30 - a) << 30);
      c = 2 * longint'(arc(ya, xa));
      return (radius * c + (64'd1 << 21)) >> 22;
    endfunction

    function void add_sat(ref longint unsigned acc, input longint unsigned v);
      acc += v;
      if (acc > SUM_MAX) begin
        acc = SUM_MAX; sat = 1;
      end
    endfunction

    // Accepted input transaction: update route state, queue a total on last stop
    function void note_stop(stop_t s);
      longint lat, lon;
      longint unsigned rest, total;
      route_total_t t;
      lat = s.lat; lon = s.lon;
      if (pos >= 1) begin
        add_sat(dist_acc, leg_km(prev_lat, prev_lon, lat, lon));
        if (!s.hub) begin
          add_sat(pen_acc, (pos * s.urg * w_urg + 128) >> 8);
          rest = legs > pos ? legs - pos : 0;
          add_sat(pen_acc, (rest * s.ano * w_ano + 128) >> 8);
        end
      end
      prev_lat = lat; prev_lon = lon;
      if (pos < rca_pkg::MAX_LEGS_DEF) pos++;
      if (s.last) begin
        total = dist_acc + pen_acc;
        if (total > SUM_MAX) begin
          total = SUM_MAX; sat = 1;
        end
        t.cost = total[rca_pkg::COST_W-1:0];
        t.ovf = sat;
        totals_q = {totals_q, t};
        clear();
      end
    endfunction

    // Output transaction: compare with the oldest predicted total
    function void check_total(logic [rca_pkg::COST_W-1:0] cost, logic ovf);
      route_total_t t;
      if (totals_q.size() == 0) begin
        $error("unexpected total: total_cost %0d overflow %0d", cost, ovf);
        errors++;
        return;
      end
      t = totals_q.pop_front();
      if (cost !== t.cost) begin
        $error("total_cost mismatch: expected %0d actual %0d", t.cost, cost);
        errors++;
      end
      if (ovf !== t.ovf) begin
        $error("overflow mismatch: expected %0d actual %0d", t.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  route_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  route_cost_accumulator dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output monitor
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_total(m_axis_tdata, m_axis_tuser);

  // Run limit
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic [15:0] wu, logic [15:0] wa, logic [15:0] rad,
                          logic [15:0] lg);
    write_reg(rca_pkg::REG_URGENCY_WEIGHT, wu);
    write_reg(rca_pkg::REG_ANOMALY_WEIGHT, wa);
    write_reg(rca_pkg::REG_EARTH_RADIUS, rad);
    write_reg(rca_pkg::REG_LEG_TOTAL, lg);
  endtask

  // Wait until every predicted total has left, then let a stop in flight finish
  task automatic drain();
    while (sb.totals_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send_stop(stop_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, s.ano, s.urg, s.lon, s.lat};
    s_axis_tuser <= s.hub;
    s_axis_tlast <= s.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_stop(s);
  endtask

  function automatic stop_t rand_stop(logic last);
    stop_t s;
    if ($urandom_range(19) == 0) begin
      s.lat = rca_pkg::LAT_W'($urandom);
      s.lon = rca_pkg::LON_W'($urandom);
    end else begin
      s.lat = rca_pkg::LAT_W'(longint'($urandom_range(754974720)) - 377487360);
      s.lon = rca_pkg::LON_W'(longint'($urandom_range(1509949440)) - 754974720);
    end
    s.hub = ($urandom_range(4) == 0);
    s.urg = s.hub ? 16'd0 : 16'($urandom);
    s.ano = s.hub ? 16'd0 : 16'($urandom);
    if ($urandom_range(9) == 0) s.urg = $urandom_range(1) ? 16'hFFFF : 16'h0;
    s.last = last;
    return s;
  endfunction

  task automatic send_route(int n);
    for (int i = 0; i < n; i++) send_stop(rand_stop(i == n - 1));
  endtask

  // Random routes, mostly short, until about the given number of stops
  task automatic random_routes(int stops);
    int n;
    while (stops > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
      send_route(n);
      stops -= n;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Directed stops; always followed by more stops, so valid is left as is
  task automatic directed();
    stop_t s;
    stop_t d[$];
    s = '{lat: 0, lon: 0, urg: 0, ano: 0, hub: 0, last: 1};
    d = {d, s};                                            // lone stop route
    s = '{lat: 377487360, lon: 754974720, urg: 16'hFFFF, ano: 16'hFFFF, hub: 0, last: 0};
    d = {d, s};
    s = '{lat: -377487360, lon: -754974720, urg: 16'hFFFF, ano: 0, hub: 0, last: 0};
    d = {d, s};                                            // pole to pole, full turn
    s = '{lat: -377487360, lon: 754974720, urg: 0, ano: 16'hFFFF, hub: 0, last: 0};
    d = {d, s};
    s = '{lat: 0, lon: 0, urg: 0, ano: 0, hub: 1, last: 0};
    d = {d, s};                                            // hub, no penalty
    s = '{lat: 30'sh1FFF_FFFF, lon: 31'sh3FFF_FFFF, urg: 16'h5555, ano: 16'hAAAA,
          hub: 0, last: 0};
    d = {d, s};                                            // latitude past the pole
    s = '{lat: 30'sh2000_0000, lon: 31'sh4000_0000, urg: 16'hAAAA, ano: 16'h5555,
          hub: 0, last: 0};
    d = {d, s};
    s = '{lat: 30'sh2000_0000, lon: 31'sh4000_0000, urg: 1, ano: 1, hub: 0, last: 0};
    d = {d, s};                                            // zero distance leg
    s = '{lat: 4194304, lon: -4194304, urg: 256, ano: 256, hub: 0, last: 1};
    d = {d, s};
    s = '{lat: 100, lon: 100, urg: 0, ano: 0, hub: 1, last: 0};
    d = {d, s};
    s = '{lat: 100, lon: 101, urg: 16'hFFFF, ano: 16'hFFFF, hub: 1, last: 1};
    d = {d, s};                                            // hub at the end
    foreach (d[i]) send_stop(d[i]);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults, no idling
    directed();
    random_routes(140);
    drain();

    // Extreme weights, position beyond leg count, sender idles
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send_idle_pct = 58;
    directed();
    random_routes(120);
    drain();

    // Zero weights, unit radius, receiver stalls and one long hold-off
    set_regs(16'd0, 16'd0, 16'd1, 16'd256);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    hold_off = 3000;
    random_routes(140);
    drain();

    // Random settings, light idling on both sides; one route long enough
    // for the position counter to saturate
    set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)), 16'd256);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    send_route(260);
    random_routes(60);
    drain();

    set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
             16'($urandom_range(1, 256)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_routes(120);

    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
